FILE: design/rpsm_pkg.sv
// Shared types and constants for the response prefix sieve matcher.
`timescale 1ns / 1ps

package rpsm_pkg;

    localparam int NUM_PATTERNS_DEF = 16;
    localparam int PATTERN_LEN_DEF  = 16;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 4;
    localparam int CPOS_W  = 4;
    localparam int PLEN_W  = 5;
    localparam int FUNC_W  = 3;
    localparam int NREG_W  = 5;

    // Input function codes as they arrive on s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 3'd0,
        FUNC_WR_BYTE = 3'd1,
        FUNC_SET_LEN = 3'd2,
        FUNC_ARM     = 3'd3,
        FUNC_ABORT   = 3'd4
    } func_t;

    // Command kinds after classification
    typedef enum logic [2:0] {
        KIND_RX,
        KIND_WR_BYTE,
        KIND_SET_LEN,
        KIND_ARM,
        KIND_ABORT
    } kind_t;

    // One classified command; pattern_length already saturated
    typedef struct packed {
        kind_t                     kind;
        logic [BYTE_W-1:0]         data_byte;
        logic [INDEX_W-1:0]        pattern_index;
        logic [CPOS_W-1:0]         char_pos;
        logic [PLEN_W-1:0]         pattern_length;
    } cmd_t;

endpackage

FILE: design/response_prefix_sieve_matcher_top.sv
// Throughput: one word per cycle while not full; the back end retires one command per cycle.
// Path: a word is queued at the accepting edge, then sieved into the output register
// when the back end pops it.
// A result held by m_tready low stops the back end; two more words fill the queue.
// Reset (aresetn low, synchronous) clears lengths, run state, waiting slot and the
// pattern count; pattern characters are not cleared and must be written before use.
`timescale 1ns / 1ps

module response_prefix_sieve_matcher_top #(
    parameter int NUM_PATTERNS = rpsm_pkg::NUM_PATTERNS_DEF,
    parameter int PATTERN_LEN  = rpsm_pkg::PATTERN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // num_registered
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // data_byte[7:0], pattern_index[11:8], char_pos[15:12],
                                      // pattern_length[20:16], zero pad
    input  logic [2:0]  s_tuser,      // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // match_valid[0], match_index[4:1], zero pad
    output logic [1:0]  m_tuser       // waiting_match[0], aborted_waiting[1]
);

    logic           keep;
    logic           full;
    logic           push;
    logic           q_valid;
    logic           q_pop;
    rpsm_pkg::cmd_t f_cmd;
    rpsm_pkg::cmd_t q_cmd;
    logic           match_valid;
    logic [3:0]     match_index;
    logic           waiting_match;
    logic           aborted_waiting;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign push      = s_tvalid && s_tready && keep;

    rpsm_front #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .PATTERN_LEN  (PATTERN_LEN)
    ) u_front (
        .func           (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .pattern_index  (s_tdata[11:8]),
        .char_pos       (s_tdata[15:12]),
        .pattern_length (s_tdata[20:16]),
        .keep           (keep),
        .cmd            (f_cmd)
    );

    rpsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (f_cmd),
        .full      (full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    rpsm_back #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .PATTERN_LEN  (PATTERN_LEN)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_valid && cfg_ready),
        .cfg_num             (cfg_data),
        .cmd_valid           (q_valid),
        .cmd                 (q_cmd),
        .cmd_pop             (q_pop),
        .res_valid           (m_tvalid),
        .res_ready           (m_tready),
        .res_match_valid     (match_valid),
        .res_match_index     (match_index),
        .res_waiting_match   (waiting_match),
        .res_aborted_waiting (aborted_waiting)
    );

    assign m_tdata = {3'b000, match_index, match_valid};
    assign m_tuser = {aborted_waiting, waiting_match};

endmodule

FILE: design/rpsm_front.sv
// Front end: decodes incoming words, range-checks them and drops no-ops.
`timescale 1ns / 1ps

module rpsm_front #(
    parameter int NUM_PATTERNS = rpsm_pkg::NUM_PATTERNS_DEF,
    parameter int PATTERN_LEN  = rpsm_pkg::PATTERN_LEN_DEF
) (
    input  logic [rpsm_pkg::FUNC_W-1:0]  func,
    input  logic [rpsm_pkg::BYTE_W-1:0]  data_byte,
    input  logic [rpsm_pkg::INDEX_W-1:0] pattern_index,
    input  logic [rpsm_pkg::CPOS_W-1:0]  char_pos,
    input  logic [rpsm_pkg::PLEN_W-1:0]  pattern_length,
    output logic                         keep,
    output rpsm_pkg::cmd_t               cmd
);

    logic idx_ok;
    logic pos_ok;

    assign idx_ok = int'(pattern_index) < NUM_PATTERNS;
    assign pos_ok = int'(char_pos) < PATTERN_LEN;

    always_comb begin
        cmd.kind          = rpsm_pkg::KIND_RX;
        cmd.data_byte     = data_byte;
        cmd.pattern_index = pattern_index;
        cmd.char_pos      = char_pos;
        cmd.pattern_length = (int'(pattern_length) > PATTERN_LEN) ?
                             rpsm_pkg::PLEN_W'(PATTERN_LEN) : pattern_length;
        keep = 1'b0;
        unique case (func)
            rpsm_pkg::FUNC_RX_BYTE: begin
                cmd.kind = rpsm_pkg::KIND_RX;
                keep     = 1'b1;
            end
            rpsm_pkg::FUNC_WR_BYTE: begin
                cmd.kind = rpsm_pkg::KIND_WR_BYTE;
                keep     = idx_ok && pos_ok;
            end
            rpsm_pkg::FUNC_SET_LEN: begin
                cmd.kind = rpsm_pkg::KIND_SET_LEN;
                keep     = idx_ok;
            end
            rpsm_pkg::FUNC_ARM: begin
                cmd.kind = rpsm_pkg::KIND_ARM;
                keep     = idx_ok;
            end
            rpsm_pkg::FUNC_ABORT: begin
                cmd.kind = rpsm_pkg::KIND_ABORT;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/rpsm_queue.sv
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps

module rpsm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rpsm_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output rpsm_pkg::cmd_t pop_cmd
);

    rpsm_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/rpsm_back.sv
// Back end: pattern table, candidate sieve, run state and result register.
`timescale 1ns / 1ps

module rpsm_back #(
    parameter int NUM_PATTERNS = rpsm_pkg::NUM_PATTERNS_DEF,
    parameter int PATTERN_LEN  = rpsm_pkg::PATTERN_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [rpsm_pkg::NREG_W-1:0]  cfg_num,
    input  logic                         cmd_valid,
    input  rpsm_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic                         res_match_valid,
    output logic [rpsm_pkg::INDEX_W-1:0] res_match_index,
    output logic                         res_waiting_match,
    output logic                         res_aborted_waiting
);

    localparam int IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int POS_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
    localparam int LEN_W = $clog2(PATTERN_LEN + 1);

    // Pattern table: one row per character position, one byte lane per pattern
    logic [NUM_PATTERNS-1:0][7:0] mem [PATTERN_LEN];
    logic [NUM_PATTERNS-1:0][7:0] row_reg;
    logic [NUM_PATTERNS-1:0][7:0] row_use;
    logic                         fwd_hit_reg;
    logic [IDX_W-1:0]             fwd_lane_reg;
    logic [7:0]                   fwd_byte_reg;

    logic [LEN_W-1:0]            len_reg [NUM_PATTERNS];
    logic [rpsm_pkg::NREG_W-1:0] num_reg_reg;
    logic [NUM_PATTERNS-1:0]     cand_reg, cand_next;
    logic [LEN_W-1:0]            pos_reg, pos_next;
    logic                        armed_reg, armed_next;
    logic [IDX_W-1:0]            went_reg, went_next;
    logic                        wcons_reg, wcons_next;
    logic                        out_valid_reg;

    logic                        res_fire;
    logic                        r_match, r_wait, r_abort;
    logic [IDX_W-1:0]            r_index;

    logic [NUM_PATTERNS-1:0]     reg_mask, cand, fit, kept, done_vec;
    logic [LEN_W-1:0]            pos_inc;
    logic [IDX_W-1:0]            last;
    logic                        wc, wdone, single, single_done;

    logic                        wr_en;
    logic [POS_W-1:0]            wr_row, rd_row;
    logic [IDX_W-1:0]            wr_lane, cmd_lane;

    assign cmd_pop  = cmd_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;

    assign cmd_lane = IDX_W'(cmd.pattern_index);
    assign wr_en    = cmd_pop && (cmd.kind == rpsm_pkg::KIND_WR_BYTE);
    assign wr_row   = POS_W'(cmd.char_pos);
    assign wr_lane  = cmd_lane;
    assign rd_row   = (int'(pos_next) >= PATTERN_LEN) ? '0 : POS_W'(pos_next);
    assign pos_inc  = pos_reg + LEN_W'(1);

    // Registered row with last cycle's write to the same row patched in
    always_comb begin
        row_use = row_reg;
        if (fwd_hit_reg) begin
            row_use[fwd_lane_reg] = fwd_byte_reg;
        end
    end

    // Parallel compare of every lane against the received byte
    always_comb begin
        last = '0;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
            reg_mask[i] = i < int'(num_reg_reg);
            fit[i]      = (pos_reg < len_reg[i]) && (row_use[i] == cmd.data_byte);
        end
        cand = (pos_reg == '0) ? reg_mask : cand_reg;
        kept = cand & fit;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
            done_vec[i] = kept[i] && (len_reg[i] == pos_inc);
            if (kept[i]) begin
                last = IDX_W'(i);
            end
        end
        single      = $onehot(kept);
        single_done = single && (|done_vec);
        wc    = ((pos_reg == '0) || wcons_reg) && armed_reg &&
                (pos_reg < len_reg[went_reg]) && (row_use[went_reg] == cmd.data_byte);
        wdone = wc && (len_reg[went_reg] == pos_inc);
    end

    always_comb begin
        cand_next  = cand_reg;
        pos_next   = pos_reg;
        armed_next = armed_reg;
        went_next  = went_reg;
        wcons_next = wcons_reg;
        res_fire   = 1'b0;
        r_match    = 1'b0;
        r_index    = '0;
        r_wait     = 1'b0;
        r_abort    = 1'b0;
        if (cmd_pop) begin
            unique case (cmd.kind)
                rpsm_pkg::KIND_RX: begin
                    if (wdone) begin
                        res_fire   = 1'b1;
                        r_match    = 1'b1;
                        r_index    = went_reg;
                        r_wait     = 1'b1;
                        armed_next = 1'b0;
                        pos_next   = '0;
                        wcons_next = 1'b1;
                    end else if (kept == '0) begin
                        pos_next   = '0;
                        wcons_next = 1'b1;
                    end else if (single_done) begin
                        res_fire   = 1'b1;
                        r_match    = 1'b1;
                        r_index    = last;
                        pos_next   = '0;
                        wcons_next = 1'b1;
                    end else begin
                        cand_next  = kept;
                        pos_next   = pos_inc;
                        wcons_next = wc;
                    end
                end
                rpsm_pkg::KIND_ARM: begin
                    if (!armed_reg) begin
                        armed_next = 1'b1;
                        went_next  = cmd_lane;
                        wcons_next = (pos_reg == '0) || cand_reg[cmd_lane];
                    end
                end
                rpsm_pkg::KIND_ABORT: begin
                    res_fire   = 1'b1;
                    r_abort    = armed_reg;
                    armed_next = 1'b0;
                    pos_next   = '0;
                    wcons_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PATTERNS; i++) begin
                len_reg[i] <= '0;
            end
            num_reg_reg   <= '0;
            cand_reg      <= '0;
            pos_reg       <= '0;
            armed_reg     <= 1'b0;
            went_reg      <= '0;
            wcons_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_reg_reg <= cfg_num;
            end
            if (cmd_pop && cmd.kind == rpsm_pkg::KIND_SET_LEN) begin
                len_reg[cmd_lane] <= LEN_W'(cmd.pattern_length);
            end
            cand_reg  <= cand_next;
            pos_reg   <= pos_next;
            armed_reg <= armed_next;
            went_reg  <= went_next;
            wcons_reg <= wcons_next;
            if (res_fire) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            res_match_valid     <= r_match;
            res_match_index     <= rpsm_pkg::INDEX_W'(r_index);
            res_waiting_match   <= r_wait;
            res_aborted_waiting <= r_abort;
        end
    end

    // Row read for the next position; a same-cycle write to that row is held aside
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_lane] <= cmd.data_byte;
        end
        row_reg      <= mem[rd_row];
        fwd_hit_reg  <= wr_en && (wr_row == rd_row);
        fwd_lane_reg <= wr_lane;
        fwd_byte_reg <= cmd.data_byte;
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the response prefix sieve matcher: directed cases, then random
// traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int NPAT = rpsm_pkg::NUM_PATTERNS_DEF;
    localparam int PLEN = rpsm_pkg::PATTERN_LEN_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    // func values the block has to ignore
    localparam logic [rpsm_pkg::FUNC_W-1:0] FUNC_RSVD_LO = 3'd5;
    localparam logic [rpsm_pkg::FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_Z = 8'h5A;

    typedef struct packed {
        logic [rpsm_pkg::FUNC_W-1:0]  func;
        logic [rpsm_pkg::BYTE_W-1:0]  data_byte;
        logic [rpsm_pkg::INDEX_W-1:0] pattern_index;
        logic [rpsm_pkg::CPOS_W-1:0]  char_pos;
        logic [rpsm_pkg::PLEN_W-1:0]  pattern_length;
    } host_cmd_t;

    typedef struct packed {
        logic                         match_valid;
        logic [rpsm_pkg::INDEX_W-1:0] match_index;
        logic                         waiting_match;
        logic                         aborted_waiting;
    } match_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    response_prefix_sieve_matcher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // matcher state as predicted
    logic [rpsm_pkg::BYTE_W-1:0]  pat_chars [NPAT][PLEN];
    logic [rpsm_pkg::PLEN_W-1:0]  pat_len [NPAT] = '{default: '0};
    logic [NPAT-1:0]              live_set = '0;
    int                           run_pos = 0;
    bit                           wait_armed = 1'b0;
    logic [rpsm_pkg::INDEX_W-1:0] wait_entry = '0;
    bit                           wait_ok = 1'b1;
    logic [rpsm_pkg::NREG_W-1:0]  nreg_cfg = '0;

    match_rec_t expected_matches [$];

    // which pattern characters have been written; lengths never reach past them
    logic [PLEN-1:0] chr_written [NPAT] = '{default: '0};
    logic [7:0]      alpha [4];
    bit              calm = 1'b0;
    int              items_sent = 0;
    int              fail_count = 0;
    int              results_seen = 0;
    int              stall_left = 0;

    function automatic void expect_word(match_rec_t r);
        expected_matches = {expected_matches, r};
    endfunction

    function automatic int eff_nreg();
        return (nreg_cfg > NPAT) ? NPAT : int'(nreg_cfg);
    endfunction

    function automatic logic [NPAT-1:0] registered_set();
        int n;
        n = eff_nreg();
        if (n >= NPAT) return '1;
        return NPAT'((33'd1 << n) - 33'd1);
    endfunction

    function automatic bit char_fits(int e, int p, logic [7:0] b);
        if (p >= PLEN || p >= pat_len[e]) return 1'b0;
        return pat_chars[e][p] == b;
    endfunction

    function automatic void start_new_run();
        run_pos = 0;
        live_set = registered_set();
        wait_ok = 1'b1;
    endfunction

    function automatic void sieve_step(host_cmd_t c);
        int p, cnt, last;
        logic [NPAT-1:0] cand, kept;
        bit wc;
        match_rec_t r;
        case (c.func)
            rpsm_pkg::FUNC_WR_BYTE: pat_chars[c.pattern_index][c.char_pos] = c.data_byte;
            rpsm_pkg::FUNC_SET_LEN:
                pat_len[c.pattern_index] = (c.pattern_length > PLEN)
                                           ? rpsm_pkg::PLEN_W'(PLEN) : c.pattern_length;
            rpsm_pkg::FUNC_ARM: begin
                if (!wait_armed) begin
                    wait_armed = 1'b1;
                    wait_entry = c.pattern_index;
                    wait_ok = (run_pos == 0) || live_set[c.pattern_index];
                end
            end
            rpsm_pkg::FUNC_ABORT: begin
                r = '{1'b0, 4'd0, 1'b0, wait_armed};
                expect_word(r);
                wait_armed = 1'b0;
                start_new_run();
            end
            rpsm_pkg::FUNC_RX_BYTE: begin
                p = run_pos;
                cand = (p == 0) ? registered_set() : live_set;
                wc = (p == 0) ? 1'b1 : wait_ok;
                wc = wc && wait_armed && char_fits(wait_entry, p, c.data_byte);
                // armed waiting pattern wins over the sieve
                if (wc && pat_len[wait_entry] == p + 1) begin
                    r = '{1'b1, wait_entry, 1'b1, 1'b0};
                    expect_word(r);
                    wait_armed = 1'b0;
                    start_new_run();
                    return;
                end
                kept = '0;
                cnt = 0;
                last = 0;
                for (int i = 0; i < NPAT; i++) begin
                    if (cand[i] && char_fits(i, p, c.data_byte)) begin
                        kept[i] = 1'b1;
                        cnt++;
                        last = i;
                    end
                end
                if (cnt == 0) begin
                    start_new_run();
                end else if (cnt == 1 && pat_len[last] == p + 1) begin
                    r = '{1'b1, rpsm_pkg::INDEX_W'(last), 1'b0, 1'b0};
                    expect_word(r);
                    start_new_run();
                end else begin
                    live_set = kept;
                    run_pos = p + 1;
                    wait_ok = wc;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic host_cmd_t mk_cmd(logic [rpsm_pkg::FUNC_W-1:0] f, logic [7:0] b,
                                         logic [3:0] e, logic [3:0] pos, logic [4:0] plen);
        host_cmd_t c;
        c.func = f;
        c.data_byte = b;
        c.pattern_index = e;
        c.char_pos = pos;
        c.pattern_length = plen;
        return c;
    endfunction

    function automatic int written_prefix(int e);
        int n;
        n = 0;
        while (n < PLEN && chr_written[e][n]) n++;
        return n;
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 9) < 7) return alpha[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    function automatic int pick_entry();
        int e, n;
        n = eff_nreg();
        for (int k = 0; k < 24; k++) begin
            e = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                     : $urandom_range(0, NPAT - 1);
            if (pat_len[e] != 0) return e;
        end
        return -1;
    endfunction

    // one word on the input stream; prediction happens at the accepting edge
    task automatic send_cmd(host_cmd_t c);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.pattern_length, c.char_pos, c.pattern_index, c.data_byte};
        s_tuser  <= c.func;
        do @(posedge aclk); while (!s_tready);
        if (c.func == rpsm_pkg::FUNC_WR_BYTE) chr_written[c.pattern_index][c.char_pos] = 1'b1;
        sieve_step(c);
        items_sent++;
    endtask

    task automatic rx_byte(logic [7:0] b);
        send_cmd(mk_cmd(rpsm_pkg::FUNC_RX_BYTE, b, 4'($urandom), 4'($urandom),
                        5'($urandom)));
    endtask

    task automatic put_char(int e, int pos, logic [7:0] b);
        send_cmd(mk_cmd(rpsm_pkg::FUNC_WR_BYTE, b, 4'(e), 4'(pos), 5'($urandom)));
    endtask

    task automatic set_len(int e, int raw);
        send_cmd(mk_cmd(rpsm_pkg::FUNC_SET_LEN, 8'($urandom), 4'(e), 4'($urandom), 5'(raw)));
    endtask

    task automatic arm(int e);
        send_cmd(mk_cmd(rpsm_pkg::FUNC_ARM, 8'($urandom), 4'(e), 4'($urandom), 5'($urandom)));
    endtask

    task automatic abort_run();
        send_cmd(mk_cmd(rpsm_pkg::FUNC_ABORT, 8'($urandom), 4'($urandom), 4'($urandom),
                        5'($urandom)));
    endtask

    task automatic feed_entry(int e, bit corrupt);
        int len, bad;
        len = pat_len[e];
        bad = corrupt ? $urandom_range(0, len - 1) : -1;
        for (int p = 0; p < len; p++)
            rx_byte((p == bad) ? noise_byte() : pat_chars[e][p]);
    endtask

    // stop sending and let every outstanding word come out
    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_nreg(logic [rpsm_pkg::NREG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        nreg_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_entry();
        int e, len, j, raw;
        bit copy;
        logic [7:0] b;
        e = $urandom_range(0, NPAT - 1);
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, PLEN);
        j = pick_entry();
        // copying the head of another pattern builds prefix overlaps
        copy = (j >= 0) && $urandom_range(0, 1);
        for (int p = 0; p < len; p++) begin
            b = (copy && p < pat_len[j]) ? pat_chars[j][p] : alpha[$urandom_range(0, 3)];
            put_char(e, p, b);
        end
        raw = (len == PLEN && $urandom_range(0, 1)) ? $urandom_range(PLEN, 31) : len;
        set_len(e, raw);
    endtask

    task automatic random_traffic(int n);
        int start, sel, e, pre, raw;
        start = items_sent;
        while (items_sent - start < n) begin
            sel = $urandom_range(0, 99);
            e = pick_entry();
            if (sel < 35) begin
                if (e >= 0) begin
                    if ($urandom_range(0, 3) == 0) abort_run();
                    feed_entry(e, $urandom_range(0, 5) == 0);
                end else begin
                    rx_byte(noise_byte());
                end
            end else if (sel < 50) begin
                if (e >= 0) begin
                    arm(e);
                    if ($urandom_range(0, 4) != 0) feed_entry(e, 1'b0);
                end else begin
                    arm($urandom_range(0, NPAT - 1));
                end
            end else if (sel < 65) begin
                load_random_entry();
            end else if (sel < 73) begin
                abort_run();
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 4)) rx_byte(noise_byte());
            end else begin
                case ($urandom_range(0, 3))
                    0: send_cmd(mk_cmd(3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI)),
                                       8'($urandom), 4'($urandom), 4'($urandom),
                                       5'($urandom)));
                    1: begin
                        e = $urandom_range(0, NPAT - 1);
                        pre = written_prefix(e);
                        raw = $urandom_range(0, 31);
                        if (((raw > PLEN) ? PLEN : raw) > pre) raw = $urandom_range(0, pre);
                        set_len(e, raw);
                    end
                    2: arm($urandom_range(0, NPAT - 1));
                    default: put_char($urandom_range(0, NPAT - 1), $urandom_range(0, PLEN - 1),
                                      8'($urandom));
                endcase
            end
        end
    endtask

    task automatic test_empty_table();
        write_nreg(5'd0);
        rx_byte(CH_A);
        abort_run();
        for (int f = FUNC_RSVD_LO; f <= FUNC_RSVD_HI; f++)
            send_cmd(mk_cmd(3'(f), 8'($urandom), 4'($urandom), 4'($urandom), 5'($urandom)));
    endtask

    // entry 0 "A" is a prefix of entry 1 "AB"; entry 3 stays empty
    task automatic test_prefix_sieve();
        put_char(0, 0, CH_A);
        set_len(0, 1);
        put_char(1, 0, CH_A);
        put_char(1, 1, CH_B);
        set_len(1, 2);
        put_char(2, 0, CH_C);
        put_char(2, 1, CH_D);
        set_len(2, 2);
        set_len(3, 0);
        wait_for_quiet();
        write_nreg(5'd4);
        rx_byte(CH_A);
        rx_byte(CH_B);
        rx_byte(CH_C);
        rx_byte(CH_D);
        rx_byte(CH_Z);
        rx_byte(CH_A);
        rx_byte(CH_A);
        rx_byte(CH_C);
        abort_run();
    endtask

    task automatic test_waiting_slot();
        arm(0);
        rx_byte(CH_A);
        arm(2);
        arm(0);
        rx_byte(CH_C);
        rx_byte(CH_D);
        // armed mid-run on an entry already dropped: must not fire
        rx_byte(CH_A);
        arm(2);
        rx_byte(CH_B);
        abort_run();
        // armed mid-run on a live candidate
        rx_byte(CH_A);
        arm(1);
        rx_byte(CH_B);
    endtask

    task automatic test_edit_mid_run();
        rx_byte(CH_C);
        put_char(2, 1, CH_E);
        rx_byte(CH_E);
    endtask

    task automatic test_full_length();
        logic [7:0] b;
        for (int i = 0; i < PLEN; i++) begin
            case (i)
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h55;
                3: b = 8'hAA;
                default: b = {4'(i), ~4'(i)};
            endcase
            put_char(NPAT - 1, i, b);
        end
        set_len(NPAT - 1, 31);
        wait_for_quiet();
        write_nreg(5'd31);
        feed_entry(NPAT - 1, 1'b0);
        set_len(NPAT - 1, PLEN);
    endtask

    task automatic test_random_phases();
        int plan [6];
        plan = '{16, $urandom_range(2, 15), 0, 31, 1, 16};
        for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
        for (int k = 0; k < 6; k++) begin
            wait_for_quiet();
            write_nreg(5'(plan[k]));
            calm = (k == 5);
            random_traffic(135);
        end
    endtask

    // result stream: random backpressure bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        match_rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[4:1], m_tuser[0], m_tuser[1]};
            results_seen++;
            if (expected_matches.size() == 0) begin
                if (fail_count < 10)
                    $display("result word %0d arrived with nothing outstanding: %p",
                             results_seen, got);
                fail_count++;
            end else begin
                want = expected_matches.pop_front();
                if (got.match_valid !== want.match_valid ||
                    got.match_index !== want.match_index ||
                    got.waiting_match !== want.waiting_match ||
                    got.aborted_waiting !== want.aborted_waiting) begin
                    if (fail_count < 10)
                        $display("result word %0d: expected %p, got %p",
                                 results_seen, want, got);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_prefix_sieve();
        test_waiting_slot();
        test_edit_mid_run();
        test_full_length();
        test_random_phases();
        wait_for_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_matches.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
design/rpsm_pkg.sv
design/rpsm_front.sv
design/rpsm_queue.sv
design/rpsm_back.sv
design/response_prefix_sieve_matcher_top.sv
tb/tb_top.sv
